/* design/xrr_pkg.sv */
// Shared types, constants and the generator step function for the xorshift range block.
// Used by every module under design/; has no dependencies of its own.
package xrr_pkg;

    localparam int WORD_W = 32;
    localparam int DIV_STEPS = WORD_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam logic [WORD_W-1:0] DEFAULT_WORD = 32'h9E37_79B9;
    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_FULL,
        KIND_MOD
    } req_kind_t;

    typedef struct packed {
        req_kind_t         kind;
        logic [WORD_W-1:0] min_bits;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] span;
    } queue_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN,
        ST_HOLD
    } back_state_t;

    function automatic logic [WORD_W-1:0] advance_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t = w ^ (w << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

endpackage

/* design/xrr_front.sv */
// Front end: accepts range requests, keeps and advances the generator word, classifies requests.
// Depends on xrr_pkg; feeds xrr_queue.
module xrr_front
    import xrr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [WORD_W-1:0]   cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [WORD_W-1:0]   in_min,
    input  logic [WORD_W-1:0]   in_max,
    input  logic                queue_full,
    output logic                push,
    output queue_entry_t        push_entry
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [WORD_W-1:0] stepped;
    logic [WORD_W-1:0] span;
    logic              empty_range;

    assign in_ready    = !queue_full;
    assign push        = in_valid && in_ready;
    assign empty_range = ($signed(in_max) <= $signed(in_min));
    assign span        = in_max - in_min + WORD_W'(1);
    assign stepped     = advance_word(word_reg);

    always_comb begin
        push_entry.min_bits = in_min;
        push_entry.span     = span;
        if (empty_range) begin
            push_entry.kind = KIND_EMPTY;
            push_entry.word = word_reg;
        end else begin
            push_entry.kind = (span == '0) ? KIND_FULL : KIND_MOD;
            push_entry.word = stepped;
        end
    end

    always_comb begin
        word_next = word_reg;
        priority if (cfg_wr_en) begin
            word_next = (cfg_wr_data == '0) ? DEFAULT_WORD : cfg_wr_data;
        end else if (push && !empty_range) begin
            word_next = stepped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= DEFAULT_WORD;
        end else begin
            word_reg <= word_next;
        end
    end

endmodule

/* design/xrr_queue.sv */
// Short first-in first-out queue of classified requests between front and back ends.
// Depends on xrr_pkg for the entry type.
module xrr_queue
    import xrr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output queue_entry_t head_entry,
    output logic         full,
    output logic         empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    queue_entry_t     slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* design/xrr_back.sv */
// Back end: takes requests from the queue, reduces the word modulo the span one bit per cycle
// where a modulo is needed, and holds the finished result in the output register. Depends on xrr_pkg.
module xrr_back
    import xrr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                queue_empty,
    input  queue_entry_t        head_entry,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WORD_W-1:0]   out_value,
    output logic [WORD_W-1:0]   out_raw
);

    back_state_t           state_reg, state_next;
    logic [WORD_W-1:0]     min_reg, min_next;
    logic [WORD_W-1:0]     raw_reg, raw_next;
    logic [WORD_W-1:0]     span_reg, span_next;
    logic [WORD_W-1:0]     quot_reg, quot_next;
    logic [WORD_W:0]       rem_reg, rem_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]     result_reg, result_next;
    logic [WORD_W:0]       rem_shift;
    logic                  last_step;

    assign rem_shift = {rem_reg[WORD_W-1:0], quot_reg[WORD_W-1]};
    assign last_step = (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!queue_empty) begin
                    state_next = (head_entry.kind == KIND_MOD) ? ST_DIV : ST_HOLD;
                end
            end
            ST_DIV: begin
                if (last_step) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        pop         = 1'b0;
        min_next    = min_reg;
        raw_next    = raw_reg;
        span_next   = span_reg;
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!queue_empty) begin
                    pop       = 1'b1;
                    min_next  = head_entry.min_bits;
                    raw_next  = head_entry.word;
                    span_next = head_entry.span;
                    quot_next = head_entry.word;
                    rem_next  = '0;
                    cnt_next  = '0;
                    unique case (head_entry.kind)
                        KIND_EMPTY: result_next = head_entry.min_bits;
                        KIND_FULL:  result_next = head_entry.word + head_entry.min_bits;
                        default:    result_next = result_reg;
                    endcase
                end
            end
            ST_DIV: begin
                rem_next  = (rem_shift >= {1'b0, span_reg}) ?
                            rem_shift - {1'b0, span_reg} : rem_shift;
                quot_next = quot_reg << 1;
                cnt_next  = cnt_reg + STEP_CNT_W'(1);
            end
            ST_FIN: begin
                result_next = rem_reg[WORD_W-1:0] + min_reg;
            end
            default: begin
            end
        endcase
    end

    assign out_valid = (state_reg == ST_HOLD);
    assign out_value = result_reg;
    assign out_raw   = raw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        min_reg    <= min_next;
        raw_reg    <= raw_next;
        span_reg   <= span_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

endmodule

/* design/xorshift_range_random_top.sv */
// Top level of the xorshift range random generator: front end, request queue and back end.
// Depends on xrr_pkg, xrr_front, xrr_queue and xrr_back.

// Each input beat carries a signed inclusive minimum and maximum and yields one output beat
// with the random value and the generator word after the request. A request whose maximum is
// not above its minimum, or whose range covers all 32-bit values, goes from the load state
// straight to the output register in the back end; any other request goes through the
// one-bit-per-cycle remainder unit, which runs 32 steps between the load and finish states.
// A result stays in the output register until it is taken. The front end advances the
// generator word as soon as a request is accepted and queues up to QUEUE_DEPTH requests, so
// input beats are taken while the back end works. A write of the seed reloads the generator
// word (zero loads 0x9E3779B9) and must be made only while no request is in flight.
module xorshift_range_random_top
    import xrr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [WORD_W-1:0]     cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*WORD_W-1:0]   s_tdata,   // range_min, range_max
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*WORD_W-1:0]   m_tdata    // random_value, raw_word
);

    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_empty;
    queue_entry_t push_entry;
    queue_entry_t head_entry;
    logic [WORD_W-1:0] out_value;
    logic [WORD_W-1:0] out_raw;

    xrr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_min      (s_tdata[WORD_W-1:0]),
        .in_max      (s_tdata[2*WORD_W-1:WORD_W]),
        .queue_full  (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    xrr_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    xrr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (q_empty),
        .head_entry  (head_entry),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_value   (out_value),
        .out_raw     (out_raw)
    );

    assign m_tdata = {out_raw, out_value};

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("request pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty)
        else $error("request popped from an empty queue");

    a_no_pop_while_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> !pop)
        else $error("back end took a new request while a result was still held");

    a_pop_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !m_tvalid)
        else $error("back end took a request while presenting a result");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for xorshift_range_random_top: directed range requests, then random
// ones under six seed settings and three handshake timing mixes, each beat checked in order.
// Depends on xrr_pkg and the design files; needs no input files.
module tb_top
    import xrr_pkg::*;
;

    localparam int RAND_PER_PHASE = 305;
    localparam int NUM_PHASES = 6;
    localparam int DRAIN_CYCLES = 40;
    localparam int NUM_DIRECTED = 20;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] raw;
    } draw_t;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        bit          known;
        logic [31:0] value;
        logic [31:0] raw;
    } range_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [WORD_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [2*WORD_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [2*WORD_W-1:0] m_tdata;

    logic [31:0] gen_word = DEFAULT_WORD;
    draw_t       pending_draws[$];
    int          mismatches = 0;
    int          draws_checked = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // Rows marked known hold results that follow directly from the reset word.
    range_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        '{32'd0, 32'd0, 1'b1, 32'd0, DEFAULT_WORD},
        '{INT_MAX, INT_MIN, 1'b1, INT_MAX, DEFAULT_WORD},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, DEFAULT_WORD},
        '{INT_MIN, INT_MIN, 1'b1, INT_MIN, DEFAULT_WORD},
        '{32'd5, -32'sd5, 1'b1, 32'd5, DEFAULT_WORD},
        '{INT_MAX, INT_MAX, 1'b1, INT_MAX, DEFAULT_WORD},
        '{INT_MIN, INT_MAX, 1'b0, '0, '0},
        '{32'd0, INT_MAX, 1'b0, '0, '0},
        '{INT_MIN, 32'hFFFF_FFFF, 1'b0, '0, '0},
        '{32'd0, 32'd1, 1'b0, '0, '0},
        '{32'hFFFF_FFFF, 32'd0, 1'b0, '0, '0},
        '{32'h7FFF_FFFE, INT_MAX, 1'b0, '0, '0},
        '{INT_MIN, 32'h8000_0001, 1'b0, '0, '0},
        '{32'd1, INT_MAX, 1'b0, '0, '0},
        '{32'h8000_0001, INT_MAX, 1'b0, '0, '0},
        '{INT_MIN, 32'h7FFF_FFFE, 1'b0, '0, '0},
        '{-32'sd10, 32'd10, 1'b0, '0, '0},
        '{32'd100, 32'd1100, 1'b0, '0, '0},
        '{-32'sd1000, -32'sd1, 1'b0, '0, '0},
        '{32'd3, 32'd4, 1'b0, '0, '0}
    };

    xorshift_range_random_top uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] xorshift_next(input logic [31:0] w);
        logic [31:0] a;
        logic [31:0] b;
        a = w ^ {w[18:0], 13'b0};
        b = a ^ {17'b0, a[31:17]};
        return b ^ {b[26:0], 5'b0};
    endfunction

    function automatic draw_t predict_draw(input logic [31:0] lo, input logic [31:0] hi);
        draw_t       d;
        logic [31:0] span;
        if ($signed(hi) <= $signed(lo)) begin
            d.value = lo;
        end else begin
            span = hi - lo + 32'd1;
            gen_word = xorshift_next(gen_word);
            if (span == 32'd0) begin
                d.value = gen_word + lo;
            end else begin
                d.value = (gen_word % span) + lo;
            end
        end
        d.raw = gen_word;
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        draw_t want;
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_draws.size() == 0) begin
                report_mismatch("unexpected beat, random_value", m_tdata[31:0], 'x);
            end else begin
                want = pending_draws.pop_front();
                draws_checked++;
                if (m_tdata[31:0] !== want.value) begin
                    report_mismatch("random_value", m_tdata[31:0], want.value);
                end
                if (m_tdata[63:32] !== want.raw) begin
                    report_mismatch("raw_word", m_tdata[63:32], want.raw);
                end
            end
        end
    end

    task automatic send_range(input logic [31:0] lo, input logic [31:0] hi,
                              input bit known, input draw_t typed);
        draw_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {hi, lo};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_draw(lo, hi);
        pending_draws.push_back(known ? typed : predicted);
    endtask

    task automatic send_random_range();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] len;
        int          pick;
        pick = $urandom_range(99);
        lo = $urandom;
        hi = $urandom;
        if (pick < 10) begin
            if ($signed(hi) > $signed(lo)) {lo, hi} = {hi, lo};
        end else if (pick < 15) begin
            lo = INT_MIN;
            hi = INT_MAX;
        end else if (pick < 55) begin
            if (pick < 40) len = $urandom_range(1000, 1);
            else len = (32'd1 << $urandom_range(31, 1)) - 32'd1;
            hi = lo + len;
            if ($signed(hi) <= $signed(lo)) begin
                hi = lo;
                lo = lo - len;
            end
        end else if ($signed(hi) < $signed(lo)) begin
            {lo, hi} = {hi, lo};
        end
        send_range(lo, hi, 1'b0, '0);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        while (pending_draws.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= seed;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gen_word = (seed != 32'd0) ? seed : DEFAULT_WORD;
    endtask

    initial begin
        logic [31:0] seeds [NUM_PHASES];
        seeds = '{DEFAULT_WORD, 32'd0, 32'hFFFF_FFFF, 32'd1, INT_MIN, $urandom};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            unique case (ph / 2)
                0: begin
                    send_idle_pct = 17;
                    recv_idle_pct = 57;
                end
                1: begin
                    send_idle_pct = 57;
                    recv_idle_pct = 17;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph == 0) begin
                foreach (directed_rows[i]) begin
                    send_range(directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].known,
                               '{directed_rows[i].value, directed_rows[i].raw});
                end
            end else begin
                write_seed(seeds[ph]);
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) send_random_range();
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        while (pending_draws.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Checked %0d result beats across %0d seed settings and three timing mixes.",
                 draws_checked, NUM_PHASES);
        $display("Seen %0d mismatches in total.", mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Timeout with %0d beats still expected.", pending_draws.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
